// File: hdl/camera_intrinsics_to_projection_defines.svh
// ----------------------------------------------------------------------------
// Camera intrinsics to projection: assertion macros
// Shared property shorthands for the clocked checks of the projection block.
// ----------------------------------------------------------------------------
`ifndef CAMERA_INTRINSICS_TO_PROJECTION_DEFINES_SVH
`define CAMERA_INTRINSICS_TO_PROJECTION_DEFINES_SVH

// Same-cycle implication, checked on the rising clock edge outside reset.
`define CITP_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("projection block check failed");

// Next-cycle implication, checked on the rising clock edge outside reset.
`define CITP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("projection block check failed");

`endif

// File: hdl/citp_pkg.sv
// ----------------------------------------------------------------------------
// Camera intrinsics to projection: package
// Widths, codes, constants and helper functions shared by the block.
// ----------------------------------------------------------------------------
package citp_pkg;

  localparam int FRAC_BITS = 16;
  localparam int DATA_W    = 32;
  localparam int QUO_W     = 31;
  localparam int NUM_W     = 66;
  localparam int DEN_W     = 33;
  localparam int NS_W      = 34 + FRAC_BITS;
  localparam int DIV_LAT   = QUO_W + 2;
  localparam int NUM_DIV   = 6;

  localparam logic [2:0] REG_ORIG_W = 3'd0;
  localparam logic [2:0] REG_ORIG_H = 3'd1;
  localparam logic [2:0] REG_OUT_W  = 3'd2;
  localparam logic [2:0] REG_OUT_H  = 3'd3;
  localparam logic [2:0] REG_NEAR   = 3'd4;
  localparam logic [2:0] REG_FAR    = 3'd5;
  localparam logic [2:0] REG_KEEP_Y = 3'd6;

  localparam logic [3:0] ELEM_M0   = 4'd0;
  localparam logic [3:0] ELEM_M5   = 4'd5;
  localparam logic [3:0] ELEM_M8   = 4'd8;
  localparam logic [3:0] ELEM_M9   = 4'd9;
  localparam logic [3:0] ELEM_M10  = 4'd10;
  localparam logic [3:0] ELEM_M11  = 4'd11;
  localparam logic [3:0] ELEM_M14  = 4'd14;
  localparam logic [3:0] ELEM_LAST = 4'd15;

  localparam int LANE_M0  = 0;
  localparam int LANE_M8  = 1;
  localparam int LANE_M5  = 2;
  localparam int LANE_M9  = 3;
  localparam int LANE_M10 = 4;
  localparam int LANE_M14 = 5;

  localparam logic signed [DATA_W-1:0] ONE_FX     = 32'sd1 <<< FRAC_BITS;
  localparam logic signed [DATA_W-1:0] NEG_ONE_FX = -ONE_FX;
  localparam logic signed [DATA_W-1:0] SAT_MAX    = 32'sh7fff_ffff;
  localparam logic signed [DATA_W-1:0] SAT_MIN    = 32'sh8000_0000;

  typedef logic signed [NS_W-1:0] ns_t;

  typedef struct packed {
    logic deg;
    logic keep;
    logic zw;
    logic zh;
    logic zd;
  } side_t;

  function automatic ns_t sext32(logic [31:0] x);
    return {{(NS_W-32){x[31]}}, x};
  endfunction

  function automatic ns_t sext33(logic [32:0] x);
    return {{(NS_W-33){x[32]}}, x};
  endfunction

endpackage

// File: hdl/camera_intrinsics_to_projection.sv
// ----------------------------------------------------------------------------
// Camera intrinsics to projection: top level
// Turns pinhole intrinsics into a 4x4 clip matrix streamed column-major.
// ----------------------------------------------------------------------------
// Each request with the valid flag set yields sixteen matrix elements, one per
// cycle while m_axis_tready is high. A finished result waits at the divider
// outputs, stalling the pipeline and s_axis_tready, until the previous matrix
// has sent its last element. Requests with the valid flag clear are taken and
// dropped. A request passes three front stages and six parallel 33-stage
// dividers before reaching the output register.
module camera_intrinsics_to_projection
  import citp_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [2:0]   cfg_idx_i,
  input  logic [31:0]  cfg_data_i,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // focal_x, center_x, focal_y, center_y
  input  logic [127:0] s_axis_tdata,
  // intrinsics_valid
  input  logic [0:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // element_index, element_value, zero padding
  output logic [39:0]  m_axis_tdata,
  // degenerate
  output logic [0:0]   m_axis_tuser,
  output logic         m_axis_tlast
);

  logic [15:0] orig_w_q, orig_h_q, out_w_q, out_h_q;
  logic [31:0] near_q, far_q;
  logic        keep_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      orig_w_q <= 16'd640;
      orig_h_q <= 16'd480;
      out_w_q  <= 16'd640;
      out_h_q  <= 16'd480;
      near_q   <= 32'd655;
      far_q    <= 32'd6553600;
      keep_q   <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_ORIG_W: orig_w_q <= cfg_data_i[15:0];
        REG_ORIG_H: orig_h_q <= cfg_data_i[15:0];
        REG_OUT_W:  out_w_q  <= cfg_data_i[15:0];
        REG_OUT_H:  out_h_q  <= cfg_data_i[15:0];
        REG_NEAR:   near_q   <= cfg_data_i;
        REG_FAR:    far_q    <= cfg_data_i;
        REG_KEEP_Y: keep_q   <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  logic adv, vend, ser_free, load;
  logic vld1_q, vld2_q, vld3_q;
  logic vld_div_q [DIV_LAT];
  side_t side1_q, side2_q, side3_q;
  side_t side_div_q [DIV_LAT];
  side_t side1_d;

  // Stage 1: register the request and the plane-derived terms.
  logic [31:0] fx1_q, cx1_q, fy1_q, cy1_q, absf1_q, absn1_q;
  logic [32:0] sum1_q, diff1_q;
  logic [32:0] sum1_d, diff1_d, absf_w, absn_w;

  assign sum1_d  = {far_q[31], far_q} + {near_q[31], near_q};
  assign diff1_d = {far_q[31], far_q} - {near_q[31], near_q};
  assign absf_w  = far_q[31] ? -{1'b1, far_q} : {1'b0, far_q};
  assign absn_w  = near_q[31] ? -{1'b1, near_q} : {1'b0, near_q};

  always_comb begin
    side1_d.zw   = (orig_w_q == '0) || (out_w_q == '0);
    side1_d.zh   = (orig_h_q == '0) || (out_h_q == '0);
    side1_d.zd   = far_q == near_q;
    side1_d.keep = keep_q;
    side1_d.deg  = side1_d.zw || side1_d.zh || side1_d.zd ||
                   (s_axis_tdata[31:0] == '0) || (s_axis_tdata[95:64] == '0);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      fx1_q   <= s_axis_tdata[31:0];
      cx1_q   <= s_axis_tdata[63:32];
      fy1_q   <= s_axis_tdata[95:64];
      cy1_q   <= s_axis_tdata[127:96];
      absf1_q <= absf_w[31:0];
      absn1_q <= absn_w[31:0];
      sum1_q  <= sum1_d;
      diff1_q <= diff1_d;
      side1_q <= side1_d;
    end
  end

  // Stage 2: signed numerators and the plane product.
  ns_t n2_q [5];
  ns_t n2_d [5];
  ns_t owf, ohf, twofy, twocy;
  logic [63:0] prod2_q;
  logic [32:0] absd2_q, absd2_d;
  logic        neg14_2_q, neg14_2_d, dneg2_q;

  assign owf   = {{(NS_W-16-FRAC_BITS){1'b0}}, orig_w_q, {FRAC_BITS{1'b0}}};
  assign ohf   = {{(NS_W-16-FRAC_BITS){1'b0}}, orig_h_q, {FRAC_BITS{1'b0}}};
  assign twofy = sext32(fy1_q) <<< 1;
  assign twocy = sext32(cy1_q) <<< 1;

  always_comb begin
    n2_d[0] = sext32(fx1_q) <<< 1;
    n2_d[1] = owf - (sext32(cx1_q) <<< 1);
    n2_d[2] = side1_q.keep ? twofy : -twofy;
    n2_d[3] = side1_q.keep ? ohf - twocy : twocy - ohf;
    n2_d[4] = -(sext33(sum1_q) <<< FRAC_BITS);
    absd2_d = diff1_q[32] ? -diff1_q : diff1_q;
    neg14_2_d = !((far_q[31] != near_q[31]) != diff1_q[32]);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < 5; i++) begin
        n2_q[i] <= n2_d[i];
      end
      prod2_q   <= absf1_q * absn1_q;
      absd2_q   <= absd2_d;
      neg14_2_q <= neg14_2_d;
      dneg2_q   <= diff1_q[32];
      side2_q   <= side1_q;
    end
  end

  // Stage 3: magnitudes with half the divisor added for rounding.
  logic [NUM_W-1:0] mag3_q [NUM_DIV];
  logic [DEN_W-1:0] den3_q [NUM_DIV];
  logic             neg3_q [NUM_DIV];
  logic [NUM_W-1:0] mag3_d [NUM_DIV];
  logic [DEN_W-1:0] den3_d [NUM_DIV];
  logic             neg3_d [NUM_DIV];

  always_comb begin
    den3_d[LANE_M0]  = DEN_W'(orig_w_q);
    den3_d[LANE_M8]  = DEN_W'(orig_w_q);
    den3_d[LANE_M5]  = DEN_W'(orig_h_q);
    den3_d[LANE_M9]  = DEN_W'(orig_h_q);
    den3_d[LANE_M10] = absd2_q;
    den3_d[LANE_M14] = absd2_q;
    for (int i = 0; i < 5; i++) begin
      mag3_d[i] = NUM_W'(n2_q[i][NS_W-1] ? -n2_q[i] : n2_q[i]) +
                  NUM_W'(den3_d[i] >> 1);
      neg3_d[i] = n2_q[i][NS_W-1];
    end
    neg3_d[LANE_M10] = n2_q[LANE_M10][NS_W-1] != dneg2_q;
    mag3_d[LANE_M14] = NUM_W'({prod2_q, 1'b0}) + NUM_W'(absd2_q >> 1);
    neg3_d[LANE_M14] = neg14_2_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < NUM_DIV; i++) begin
        mag3_q[i] <= mag3_d[i];
        den3_q[i] <= den3_d[i];
        neg3_q[i] <= neg3_d[i];
      end
      side3_q <= side2_q;
    end
  end

  logic signed [DATA_W-1:0] div_res [NUM_DIV];

  for (genvar g = 0; g < NUM_DIV; g++) begin : g_div
    citp_divider u_div (
      .clk_i (clk_i),
      .en_i  (adv),
      .num_i (mag3_q[g]),
      .den_i (den3_q[g]),
      .neg_i (neg3_q[g]),
      .res_o (div_res[g])
    );
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      side_div_q[0] <= side3_q;
      for (int i = 1; i < DIV_LAT; i++) begin
        side_div_q[i] <= side_div_q[i-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
      vld2_q <= 1'b0;
      vld3_q <= 1'b0;
      for (int i = 0; i < DIV_LAT; i++) begin
        vld_div_q[i] <= 1'b0;
      end
    end else if (adv) begin
      vld1_q       <= s_axis_tvalid && s_axis_tuser[0];
      vld2_q       <= vld1_q;
      vld3_q       <= vld2_q;
      vld_div_q[0] <= vld3_q;
      for (int i = 1; i < DIV_LAT; i++) begin
        vld_div_q[i] <= vld_div_q[i-1];
      end
    end
  end

  // Output serializer.
  logic out_vld_q, out_vld_d;
  logic [3:0] idx_q, idx_d;
  logic signed [DATA_W-1:0] e0_q, e8_q, e5_q, e9_q, e10_q, e14_q;
  logic deg_q;
  logic signed [DATA_W-1:0] value;
  side_t se;

  assign se       = side_div_q[DIV_LAT-1];
  assign vend     = vld_div_q[DIV_LAT-1];
  assign ser_free = !out_vld_q || (m_axis_tready && (idx_q == ELEM_LAST));
  assign load     = vend && ser_free;
  assign adv      = !vend || ser_free;
  assign s_axis_tready = adv;

  always_ff @(posedge clk_i) begin
    if (load) begin
      e0_q  <= se.zw ? '0 : div_res[LANE_M0];
      e8_q  <= se.zw ? ONE_FX : div_res[LANE_M8];
      e5_q  <= se.zh ? '0 : div_res[LANE_M5];
      e9_q  <= se.zh ? (se.keep ? ONE_FX : NEG_ONE_FX) : div_res[LANE_M9];
      e10_q <= se.zd ? '0 : div_res[LANE_M10];
      e14_q <= se.zd ? '0 : div_res[LANE_M14];
      deg_q <= se.deg;
    end
  end

  always_comb begin
    out_vld_d = out_vld_q;
    idx_d     = idx_q;
    if (load) begin
      out_vld_d = 1'b1;
      idx_d     = '0;
    end else if (out_vld_q && m_axis_tready) begin
      out_vld_d = idx_q != ELEM_LAST;
      idx_d     = idx_q + 4'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
      idx_q     <= '0;
    end else begin
      out_vld_q <= out_vld_d;
      idx_q     <= idx_d;
    end
  end

  always_comb begin
    case (idx_q)
      ELEM_M0:  value = e0_q;
      ELEM_M5:  value = e5_q;
      ELEM_M8:  value = e8_q;
      ELEM_M9:  value = e9_q;
      ELEM_M10: value = e10_q;
      ELEM_M11: value = NEG_ONE_FX;
      ELEM_M14: value = e14_q;
      default:  value = '0;
    endcase
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {4'b0000, value, idx_q};
  assign m_axis_tuser  = deg_q;
  assign m_axis_tlast  = idx_q == ELEM_LAST;

`include "camera_intrinsics_to_projection_defines.svh"

  `CITP_ASSERT_NEXT(a_idx_step, m_axis_tvalid && m_axis_tready && !m_axis_tlast, m_axis_tvalid && (idx_q == 4'($past(idx_q) + 4'd1)))
  `CITP_ASSERT_IMPL(a_stall_busy, vend && !adv, out_vld_q && !(m_axis_tready && (idx_q == ELEM_LAST)))
  `CITP_ASSERT_NEXT(a_drop_invalid, s_axis_tvalid && s_axis_tready && !s_axis_tuser[0], !vld1_q)

endmodule

// File: hdl/citp_divider.sv
// ----------------------------------------------------------------------------
// Camera intrinsics to projection: pipelined divider
// Restoring division, one quotient bit per stage, with signed saturation.
// ----------------------------------------------------------------------------
module citp_divider
  import citp_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic [NUM_W-1:0]         num_i,
  input  logic [DEN_W-1:0]         den_i,
  input  logic                     neg_i,
  output logic signed [DATA_W-1:0] res_o
);

  logic [NUM_W-1:0] rem_q [QUO_W+1];
  logic [DEN_W-1:0] den_q [QUO_W+1];
  logic [QUO_W-1:0] quo_q [QUO_W+1];
  logic             neg_q [QUO_W+1];
  logic             sat_q [QUO_W+1];
  logic signed [DATA_W-1:0] res_q, res_d;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= num_i;
      den_q[0] <= den_i;
      quo_q[0] <= '0;
      neg_q[0] <= neg_i;
      sat_q[0] <= num_i >= (NUM_W'(den_i) << QUO_W);
    end
  end

  for (genvar k = 1; k <= QUO_W; k++) begin : g_stage
    localparam int B = QUO_W - k;
    logic [NUM_W-1:0] shifted;
    logic             ge;
    assign shifted = NUM_W'(den_q[k-1]) << B;
    assign ge      = rem_q[k-1] >= shifted;
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= ge ? rem_q[k-1] - shifted : rem_q[k-1];
        den_q[k] <= den_q[k-1];
        quo_q[k] <= quo_q[k-1] | (QUO_W'(ge) << B);
        neg_q[k] <= neg_q[k-1];
        sat_q[k] <= sat_q[k-1];
      end
    end
  end

  always_comb begin
    if (sat_q[QUO_W]) begin
      res_d = neg_q[QUO_W] ? SAT_MIN : SAT_MAX;
    end else if (neg_q[QUO_W]) begin
      res_d = -$signed({1'b0, quo_q[QUO_W]});
    end else begin
      res_d = $signed({1'b0, quo_q[QUO_W]});
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_q <= res_d;
    end
  end

  assign res_o = res_q;

endmodule
